// File: design/krt_pkg.sv
// ----------------------------------------------------------------------------
// krt_pkg: shared types for the keyed record table
// Opcodes, status codes, the stored record layout and store commands.
// ----------------------------------------------------------------------------
`default_nettype none

package krt_pkg;

  localparam int KEY_W   = 16;
  localparam int SLOT_W  = 4;
  localparam int MAX_OUT = 16;
  localparam int CNT_W   = $clog2(MAX_OUT + 1);

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_LIST   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_DUP      = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef struct packed {
    logic [6:0]  age;
    logic [7:0]  sex;
    logic [3:0]  grade_one;
    logic [3:0]  grade_two;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } rec_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_en;
  } store_cmd_t;

endpackage

`default_nettype wire

// File: design/krt_store.sv
// ----------------------------------------------------------------------------
// krt_store: slot storage
// Key and record memories with registered reads, plus the
// per-slot valid bits, cleared at reset and read alongside the memories.
// ----------------------------------------------------------------------------
`default_nettype none

module krt_store #(
  parameter int TABLE_SLOTS = 16,
  parameter int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire krt_pkg::store_cmd_t cmd,
  input  wire logic [IDX_W-1:0]    rd_addr,
  input  wire logic [IDX_W-1:0]    wr_addr,
  input  wire krt_pkg::key_t       wr_key,
  input  wire krt_pkg::rec_t       wr_rec,
  output krt_pkg::key_t            rsp_key,
  output krt_pkg::rec_t            rsp_rec,
  output logic                     rsp_valid
);

  krt_pkg::key_t           key_mem [TABLE_SLOTS];
  krt_pkg::rec_t           rec_mem [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0]  valid;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      key_mem[wr_addr] <= wr_key;
      rec_mem[wr_addr] <= wr_rec;
    end
    if (cmd.rd_en) begin
      rsp_key <= key_mem[rd_addr];
      rsp_rec <= rec_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (cmd.clr_en) begin
        valid[wr_addr] <= 1'b0;
      end
      if (cmd.rd_en) begin
        rsp_valid <= valid[rd_addr];
      end
    end
  end

endmodule

`default_nettype wire

// File: design/krt_ctrl.sv
// ----------------------------------------------------------------------------
// krt_ctrl: operation sequencer
// Scans every slot through the store, tracks the first free slot and the
// key match, streams list words and writes back at the end of a pass.
// ----------------------------------------------------------------------------
`default_nettype none

module krt_ctrl #(
  parameter int TABLE_SLOTS = 16,
  parameter int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire krt_pkg::opcode_t    opcode,
  input  wire krt_pkg::key_t       key,
  input  wire krt_pkg::rec_t       rec,
  output krt_pkg::store_cmd_t      cmd,
  output logic [IDX_W-1:0]         rd_addr,
  output logic [IDX_W-1:0]         wr_addr,
  output krt_pkg::key_t            wr_key,
  output krt_pkg::rec_t            wr_rec,
  input  wire krt_pkg::key_t       rsp_key,
  input  wire krt_pkg::rec_t       rsp_rec,
  input  wire logic                rsp_valid,
  output logic                     out_strobe,
  output krt_pkg::status_t         out_status,
  output krt_pkg::slot_t           out_slot,
  output krt_pkg::key_t            out_key,
  output krt_pkg::rec_t            out_rec,
  output logic                     out_last
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_DONE
  } state_t;

  state_t             state;
  krt_pkg::opcode_t   op_q;
  krt_pkg::key_t      key_q;
  krt_pkg::rec_t      rec_q;
  logic [IDX_W-1:0]   scan_idx;
  logic               rsp_en;
  logic [IDX_W-1:0]   rsp_idx;
  logic               have_free;
  logic [IDX_W-1:0]   free_idx;
  logic               have_match;
  logic [IDX_W-1:0]   match_idx;
  krt_pkg::rec_t      match_rec;
  logic               pend_ok;
  logic [IDX_W-1:0]   pend_idx;
  krt_pkg::key_t      pend_key;
  krt_pkg::rec_t      pend_rec;
  krt_pkg::cnt_t      list_cnt;

  assign busy       = (state != S_IDLE);
  assign rd_addr    = scan_idx;
  assign wr_addr    = (op_q == krt_pkg::OP_INSERT) ? free_idx : match_idx;
  assign wr_key     = key_q;
  assign wr_rec     = rec_q;
  assign cmd.rd_en  = (state == S_SCAN);
  assign cmd.wr_en  = (state == S_DONE) && (op_q == krt_pkg::OP_INSERT) &&
                      have_free && !have_match;
  assign cmd.clr_en = (state == S_DONE) && (op_q == krt_pkg::OP_DELETE) && have_match;

  always_ff @(posedge clk) begin
    rsp_idx <= scan_idx;
    if (rst) begin
      state      <= S_IDLE;
      out_strobe <= 1'b0;
      rsp_en     <= 1'b0;
      list_cnt   <= '0;
    end else begin
      out_strobe <= 1'b0;
      rsp_en     <= (state == S_SCAN);
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_q       <= opcode;
            key_q      <= key;
            rec_q      <= rec;
            scan_idx   <= '0;
            have_free  <= 1'b0;
            have_match <= 1'b0;
            pend_ok    <= 1'b0;
            list_cnt   <= '0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          scan_idx <= scan_idx + 1'b1;
          if (scan_idx == LAST_IDX) begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          state <= S_DONE;
        end
        S_DONE: begin
          out_strobe <= 1'b1;
          out_last   <= 1'b1;
          out_status <= krt_pkg::ST_OK;
          out_slot   <= '0;
          out_key    <= '0;
          out_rec    <= '0;
          unique case (op_q) inside
            krt_pkg::OP_INSERT: begin
              if (!have_free) begin
                out_status <= krt_pkg::ST_FULL;
              end else if (have_match) begin
                out_status <= krt_pkg::ST_DUP;
                out_slot   <= krt_pkg::slot_t'(match_idx);
                out_key    <= key_q;
                out_rec    <= match_rec;
              end else begin
                out_slot <= krt_pkg::slot_t'(free_idx);
                out_key  <= key_q;
                out_rec  <= rec_q;
              end
            end
            krt_pkg::OP_DELETE, krt_pkg::OP_LOOKUP: begin
              if (have_match) begin
                out_slot <= krt_pkg::slot_t'(match_idx);
                out_key  <= key_q;
                out_rec  <= match_rec;
              end else begin
                out_status <= krt_pkg::ST_NOTFOUND;
              end
            end
            krt_pkg::OP_LIST: begin
              if (pend_ok) begin
                out_slot <= krt_pkg::slot_t'(pend_idx);
                out_key  <= pend_key;
                out_rec  <= pend_rec;
              end else begin
                out_status <= krt_pkg::ST_EMPTY;
              end
            end
          endcase
          state <= S_IDLE;
        end
      endcase

      if (rsp_en) begin
        if (!rsp_valid && !have_free) begin
          have_free <= 1'b1;
          free_idx  <= rsp_idx;
        end
        if (rsp_valid && (rsp_key == key_q) && !have_match) begin
          have_match <= 1'b1;
          match_idx  <= rsp_idx;
          match_rec  <= rsp_rec;
        end
        if ((op_q == krt_pkg::OP_LIST) && rsp_valid &&
            (list_cnt < krt_pkg::CNT_W'(krt_pkg::MAX_OUT))) begin
          if (pend_ok) begin
            out_strobe <= 1'b1;
            out_last   <= 1'b0;
            out_status <= krt_pkg::ST_OK;
            out_slot   <= krt_pkg::slot_t'(pend_idx);
            out_key    <= pend_key;
            out_rec    <= pend_rec;
          end
          pend_ok  <= 1'b1;
          pend_idx <= rsp_idx;
          pend_key <= rsp_key;
          pend_rec <= rsp_rec;
          list_cnt <= list_cnt + 1'b1;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_done_emits_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> out_strobe && out_last)
    else $error("operation ended without a final word");

  a_mid_list_busy: assert property (@(posedge clk) disable iff (rst)
    out_strobe && !out_last |-> busy && (op_q == krt_pkg::OP_LIST))
    else $error("non-final word outside a list pass");

  a_rsp_in_scan: assert property (@(posedge clk) disable iff (rst)
    rsp_en |-> (state == S_SCAN) || (state == S_LAST))
    else $error("store response outside a scan");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_strobe && ((out_status == krt_pkg::ST_FULL) ||
                   (out_status == krt_pkg::ST_NOTFOUND) ||
                   (out_status == krt_pkg::ST_EMPTY))
    |-> (out_key == '0) && (out_rec == '0) && (out_slot == '0))
    else $error("failure word carries record fields");

  a_list_cap: assert property (@(posedge clk) disable iff (rst)
    list_cnt <= krt_pkg::CNT_W'(krt_pkg::MAX_OUT))
    else $error("list count past limit");
`endif

endmodule

`default_nettype wire

// File: design/keyed_record_table.sv
// ----------------------------------------------------------------------------
// keyed_record_table: fixed slot table of keyed records
// Insert, delete, lookup and list over TABLE_SLOTS slots with valid bits.
// ----------------------------------------------------------------------------
// Usage:
//   Drive opcode, key and record fields with start high; the word is taken
//   at an edge where start is high and busy is low. busy stays high until
//   the operation has finished.
//   Every operation reads all slots in turn from the store, one slot a
//   cycle, so busy stays high through the scan and the closing states. A
//   new word can be taken at the edge that ends the first cycle with busy
//   low; no new word is taken while an operation is in progress.
//   Results appear on the result ports for one cycle with strobe high;
//   the final result of an operation has last high and appears in the
//   first cycle with busy low. A list operation also emits its earlier
//   records during the scan, at most one per cycle, in slot order, up to
//   fifteen. The receiver cannot stall; each result must be taken when shown.
//   Reset empties every slot at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_record_table #(
  parameter int TABLE_SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  opcode,
  input  wire logic [15:0] key,
  input  wire logic [6:0]  age,
  input  wire logic [7:0]  sex,
  input  wire logic [3:0]  grade_one,
  input  wire logic [3:0]  grade_two,
  input  wire logic [4:0]  day,
  input  wire logic [3:0]  month,
  input  wire logic [13:0] year,
  output logic             strobe,
  output logic [2:0]       status,
  output logic [3:0]       slot,
  output logic [15:0]      found_key,
  output logic [6:0]       found_age,
  output logic [7:0]       found_sex,
  output logic [3:0]       found_grade_one,
  output logic [3:0]       found_grade_two,
  output logic [4:0]       average_halves,
  output logic [4:0]       found_day,
  output logic [3:0]       found_month,
  output logic [13:0]      found_year,
  output logic             last
);

  localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

  krt_pkg::rec_t        rec_in;
  krt_pkg::store_cmd_t  cmd;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     wr_addr;
  krt_pkg::key_t        wr_key;
  krt_pkg::rec_t        wr_rec;
  krt_pkg::key_t        rsp_key;
  krt_pkg::rec_t        rsp_rec;
  logic                 rsp_valid;
  krt_pkg::status_t     out_status;
  krt_pkg::rec_t        out_rec;

  assign rec_in.age       = age;
  assign rec_in.sex       = sex;
  assign rec_in.grade_one = grade_one;
  assign rec_in.grade_two = grade_two;
  assign rec_in.day       = day;
  assign rec_in.month     = month;
  assign rec_in.year      = year;

  krt_ctrl #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .IDX_W       (IDX_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (krt_pkg::opcode_t'(opcode)),
    .key        (key),
    .rec        (rec_in),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .wr_key     (wr_key),
    .wr_rec     (wr_rec),
    .rsp_key    (rsp_key),
    .rsp_rec    (rsp_rec),
    .rsp_valid  (rsp_valid),
    .out_strobe (strobe),
    .out_status (out_status),
    .out_slot   (slot),
    .out_key    (found_key),
    .out_rec    (out_rec),
    .out_last   (last)
  );

  krt_store #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .IDX_W       (IDX_W)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .wr_key    (wr_key),
    .wr_rec    (wr_rec),
    .rsp_key   (rsp_key),
    .rsp_rec   (rsp_rec),
    .rsp_valid (rsp_valid)
  );

  assign status          = out_status;
  assign found_age       = out_rec.age;
  assign found_sex       = out_rec.sex;
  assign found_grade_one = out_rec.grade_one;
  assign found_grade_two = out_rec.grade_two;
  assign average_halves  = {1'b0, out_rec.grade_one} + {1'b0, out_rec.grade_two};
  assign found_day       = out_rec.day;
  assign found_month     = out_rec.month;
  assign found_year      = out_rec.year;

endmodule

`default_nettype wire
